### rtl/core/mtsc_pkg.sv
package mtsc_pkg;

    localparam int LEVELS_DEF           = 16;
    localparam int MAP_COUNT_BITS_DEF   = 17;
    localparam int LAYER_COUNT_BITS_DEF = 24;
    localparam int TOTAL_COUNT_BITS_DEF = 32;

    localparam int EMPTY_BITS    = 16;
    localparam int MAG_BITS      = 15;
    localparam int SAMPLE_BITS   = 16;
    localparam int LEVEL_BITS    = 4;
    localparam int LAYER_FIELD_W = 24;
    localparam int TOTAL_FIELD_W = 32;
    localparam int EMPTY_FIELD_W = 16;
    localparam int OUT_FIELDS_W  = LEVEL_BITS + 2 * LAYER_FIELD_W + 2 * TOTAL_FIELD_W
                                   + EMPTY_FIELD_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic accept;
        logic end_map;
        logic end_layer;
        logic load;
        logic shift;
    } mtsc_ctrl_t;

    function automatic logic [MAG_BITS-1:0] thr_q88(input logic [LEVEL_BITS-1:0] l);
        logic [MAG_BITS-1:0] t;
        unique case (l)
            4'd0:    t = 15'd7680;
            4'd1:    t = 15'd5120;
            4'd2:    t = 15'd2560;
            4'd3:    t = 15'd1280;
            4'd4:    t = 15'd1024;
            4'd5:    t = 15'd768;
            4'd6:    t = 15'd512;
            4'd7:    t = 15'd256;
            4'd8:    t = 15'd204;
            4'd9:    t = 15'd153;
            4'd10:   t = 15'd128;
            4'd11:   t = 15'd102;
            4'd12:   t = 15'd76;
            4'd13:   t = 15'd51;
            4'd14:   t = 15'd25;
            default: t = 15'd0;
        endcase
        return t;
    endfunction

endpackage

### rtl/core/mtsc_cell.sv
module mtsc_cell #(
    parameter int LEVEL            = 0,
    parameter int MAP_COUNT_BITS   = mtsc_pkg::MAP_COUNT_BITS_DEF,
    parameter int LAYER_COUNT_BITS = mtsc_pkg::LAYER_COUNT_BITS_DEF,
    parameter int TOTAL_COUNT_BITS = mtsc_pkg::TOTAL_COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mtsc_pkg::mtsc_ctrl_t              ctrl,
    input  logic [mtsc_pkg::MAG_BITS-1:0]     mag,
    input  logic [MAP_COUNT_BITS-1:0]         map_sample_inc,
    input  logic [LAYER_COUNT_BITS-1:0]       snap_layer_in,
    input  logic [TOTAL_COUNT_BITS-1:0]       snap_total_in,
    input  logic [mtsc_pkg::EMPTY_BITS-1:0]   snap_empty_in,
    output logic [LAYER_COUNT_BITS-1:0]       snap_layer,
    output logic [TOTAL_COUNT_BITS-1:0]       snap_total,
    output logic [mtsc_pkg::EMPTY_BITS-1:0]   snap_empty
);
    import mtsc_pkg::*;

    localparam logic [MAG_BITS-1:0] THR = thr_q88(LEVEL_BITS'(LEVEL));

    logic [MAP_COUNT_BITS-1:0]   map_reg,   map_next,   map_inc;
    logic [LAYER_COUNT_BITS-1:0] layer_reg, layer_next, layer_inc;
    logic [TOTAL_COUNT_BITS-1:0] total_reg, total_next, total_inc;
    logic [EMPTY_BITS-1:0]       empty_reg, empty_next, empty_inc;
    logic [LAYER_COUNT_BITS-1:0] snap_layer_reg, snap_layer_next;
    logic [TOTAL_COUNT_BITS-1:0] snap_total_reg, snap_total_next;
    logic [EMPTY_BITS-1:0]       snap_empty_reg, snap_empty_next;
    logic                        hit;

    assign hit = (mag <= THR);

    always_comb begin
        map_inc   = (hit && !(&map_reg))   ? map_reg + 1'b1   : map_reg;
        layer_inc = (hit && !(&layer_reg)) ? layer_reg + 1'b1 : layer_reg;
        total_inc = (hit && !(&total_reg)) ? total_reg + 1'b1 : total_reg;
        empty_inc = (ctrl.end_map && (map_inc == map_sample_inc) && !(&empty_reg))
                    ? empty_reg + 1'b1 : empty_reg;

        map_next   = map_reg;
        layer_next = layer_reg;
        total_next = total_reg;
        empty_next = empty_reg;
        if (ctrl.accept) begin
            map_next   = ctrl.end_map   ? '0 : map_inc;
            layer_next = ctrl.end_layer ? '0 : layer_inc;
            total_next = total_inc;
            empty_next = ctrl.end_layer ? '0 : empty_inc;
        end

        snap_layer_next = snap_layer_reg;
        snap_total_next = snap_total_reg;
        snap_empty_next = snap_empty_reg;
        if (ctrl.load) begin
            snap_layer_next = layer_inc;
            snap_total_next = total_inc;
            snap_empty_next = empty_inc;
        end else if (ctrl.shift) begin
            snap_layer_next = snap_layer_in;
            snap_total_next = snap_total_in;
            snap_empty_next = snap_empty_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg   <= '0;
            layer_reg <= '0;
            total_reg <= '0;
            empty_reg <= '0;
        end else begin
            map_reg   <= map_next;
            layer_reg <= layer_next;
            total_reg <= total_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_layer_reg <= snap_layer_next;
        snap_total_reg <= snap_total_next;
        snap_empty_reg <= snap_empty_next;
    end

    assign snap_layer = snap_layer_reg;
    assign snap_total = snap_total_reg;
    assign snap_empty = snap_empty_reg;

endmodule

### rtl/core/multi_threshold_sparsity_counter_core.sv
// Multi-threshold sparsity counter.
// Input stream: one signed Q8.8 sample per request in s_tdata, s_tuser marks
// the last sample of a map, s_tlast the last sample of a layer (also ends
// the map). Samples are taken one per cycle; the magnitude is compared
// against all threshold levels at once in a row of level cells.
// Output stream: at each layer end the cells load a snapshot of their
// counters and shift it toward m_tdata, one result per level, level 0
// first, m_tlast on the last level. The first result is valid in the cycle
// after the layer-end sample is accepted.
// Samples that do not end a layer are accepted while a run drains. A
// layer-end sample waits (s_tready low) until the snapshot row is free,
// that is until the last result of the previous run is taken; while the
// receiver stalls the current result holds on m_tdata.
// Reset (aresetn low, synchronous) clears every map, layer and all-time
// counter and drops any run in flight.
module multi_threshold_sparsity_counter_core #(
    parameter int LEVELS           = mtsc_pkg::LEVELS_DEF,
    parameter int MAP_COUNT_BITS   = mtsc_pkg::MAP_COUNT_BITS_DEF,
    parameter int LAYER_COUNT_BITS = mtsc_pkg::LAYER_COUNT_BITS_DEF,
    parameter int TOTAL_COUNT_BITS = mtsc_pkg::TOTAL_COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mtsc_pkg::SAMPLE_BITS-1:0]    s_tdata,  // sample
    input  logic                                s_tuser,  // last_in_map
    input  logic                                s_tlast,  // last_in_layer
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // level, layer_small_count, layer_sample_count, total_small_count,
    // total_sample_count, empty_map_count, zero pad
    output logic [mtsc_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast   // last_level
);
    import mtsc_pkg::*;

    localparam int CW = $clog2(LEVELS + 1);

    mtsc_ctrl_t                  ctrl;
    logic                        accept, out_fire, load_ok;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [MAP_COUNT_BITS-1:0]   map_cnt_reg, map_cnt_next, map_cnt_inc;
    logic [LAYER_COUNT_BITS-1:0] layer_cnt_reg, layer_cnt_next, layer_cnt_inc;
    logic [TOTAL_COUNT_BITS-1:0] total_cnt_reg, total_cnt_next, total_cnt_inc;
    logic [LAYER_COUNT_BITS-1:0] snap_lcnt_reg, snap_lcnt_next;
    logic [TOTAL_COUNT_BITS-1:0] snap_tcnt_reg, snap_tcnt_next;
    logic [MAG_BITS-1:0]         mag;
    logic [SAMPLE_BITS-1:0]      neg;

    logic [LAYER_COUNT_BITS-1:0] snap_layer [LEVELS+1];
    logic [TOTAL_COUNT_BITS-1:0] snap_total [LEVELS+1];
    logic [EMPTY_BITS-1:0]       snap_empty [LEVELS+1];

    logic [63:0]                 w_layer_small, w_layer_cnt, w_total_small, w_total_cnt;
    logic [LEVEL_BITS:0]         level_w;

    assign out_fire = m_tvalid && m_tready;
    assign load_ok  = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && m_tready);
    assign s_tready = load_ok || !s_tlast;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        neg = SAMPLE_BITS'(0) - s_tdata;
        if (!s_tdata[SAMPLE_BITS-1]) begin
            mag = s_tdata[MAG_BITS-1:0];
        end else if (neg[SAMPLE_BITS-1]) begin
            mag = '1;
        end else begin
            mag = neg[MAG_BITS-1:0];
        end
    end

    always_comb begin
        ctrl.accept    = accept;
        ctrl.end_layer = s_tlast;
        ctrl.end_map   = s_tuser || s_tlast;
        ctrl.load      = accept && s_tlast;
        ctrl.shift     = out_fire;

        map_cnt_inc   = (&map_cnt_reg)   ? map_cnt_reg   : map_cnt_reg + 1'b1;
        layer_cnt_inc = (&layer_cnt_reg) ? layer_cnt_reg : layer_cnt_reg + 1'b1;
        total_cnt_inc = (&total_cnt_reg) ? total_cnt_reg : total_cnt_reg + 1'b1;

        map_cnt_next   = map_cnt_reg;
        layer_cnt_next = layer_cnt_reg;
        total_cnt_next = total_cnt_reg;
        if (accept) begin
            map_cnt_next   = ctrl.end_map   ? '0 : map_cnt_inc;
            layer_cnt_next = ctrl.end_layer ? '0 : layer_cnt_inc;
            total_cnt_next = total_cnt_inc;
        end

        snap_lcnt_next = snap_lcnt_reg;
        snap_tcnt_next = snap_tcnt_reg;
        cnt_next       = cnt_reg;
        priority if (ctrl.load) begin
            snap_lcnt_next = layer_cnt_inc;
            snap_tcnt_next = total_cnt_inc;
            cnt_next       = CW'(LEVELS);
        end else if (out_fire) begin
            cnt_next = cnt_reg - 1'b1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            map_cnt_reg   <= '0;
            layer_cnt_reg <= '0;
            total_cnt_reg <= '0;
        end else begin
            cnt_reg       <= cnt_next;
            map_cnt_reg   <= map_cnt_next;
            layer_cnt_reg <= layer_cnt_next;
            total_cnt_reg <= total_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_lcnt_reg <= snap_lcnt_next;
        snap_tcnt_reg <= snap_tcnt_next;
    end

    assign snap_layer[LEVELS] = '0;
    assign snap_total[LEVELS] = '0;
    assign snap_empty[LEVELS] = '0;

    for (genvar i = 0; i < LEVELS; i++) begin : g_cell
        mtsc_cell #(
            .LEVEL            (i),
            .MAP_COUNT_BITS   (MAP_COUNT_BITS),
            .LAYER_COUNT_BITS (LAYER_COUNT_BITS),
            .TOTAL_COUNT_BITS (TOTAL_COUNT_BITS)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (ctrl),
            .mag            (mag),
            .map_sample_inc (map_cnt_inc),
            .snap_layer_in  (snap_layer[i+1]),
            .snap_total_in  (snap_total[i+1]),
            .snap_empty_in  (snap_empty[i+1]),
            .snap_layer     (snap_layer[i]),
            .snap_total     (snap_total[i]),
            .snap_empty     (snap_empty[i])
        );
    end

    assign w_layer_small = 64'(snap_layer[0]);
    assign w_layer_cnt   = 64'(snap_lcnt_reg);
    assign w_total_small = 64'(snap_total[0]);
    assign w_total_cnt   = 64'(snap_tcnt_reg);
    assign level_w       = (LEVEL_BITS + 1)'(LEVELS) - (LEVEL_BITS + 1)'(cnt_reg);

    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = (cnt_reg == CW'(1));
    assign m_tdata  = OUT_DATA_W'({
        snap_empty[0][EMPTY_FIELD_W-1:0],
        w_total_cnt[TOTAL_FIELD_W-1:0],
        w_total_small[TOTAL_FIELD_W-1:0],
        w_layer_cnt[LAYER_FIELD_W-1:0],
        w_layer_small[LAYER_FIELD_W-1:0],
        level_w[LEVEL_BITS-1:0]
    });

endmodule

### rtl/core/mtsc_checker.sv
module mtsc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [mtsc_pkg::SAMPLE_BITS-1:0] s_tdata,
    input logic                             s_tuser,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mtsc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);
    import mtsc_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_layer_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("layer end did not start a result run");

    a_level_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[LEVEL_BITS-1:0] ==
                         $past(m_tdata[LEVEL_BITS-1:0]) + 1'b1))
        else $error("result run broken or level out of order");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind multi_threshold_sparsity_counter_core mtsc_checker u_mtsc_checker (.*);

### tb/tb_multi_threshold_sparsity_counter_core.sv
module tb_multi_threshold_sparsity_counter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mtsc_pkg::*;

    localparam int LEVEL_COUNT = 16;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_SAMPLES = 110;

    typedef struct packed {
        logic [OUT_DATA_W-OUT_FIELDS_W-1:0] pad;
        logic [EMPTY_FIELD_W-1:0]           empty_maps;
        logic [TOTAL_FIELD_W-1:0]           all_total;
        logic [TOTAL_FIELD_W-1:0]           all_small;
        logic [LAYER_FIELD_W-1:0]           layer_total;
        logic [LAYER_FIELD_W-1:0]           layer_small;
        logic [LEVEL_BITS-1:0]              level;
    } level_word_t;

    class sparsity_tally;
        int unsigned       level_limit[LEVEL_COUNT];
        longint unsigned   map_small[LEVEL_COUNT];
        longint unsigned   empty_maps[LEVEL_COUNT];
        longint unsigned   layer_small[LEVEL_COUNT];
        longint unsigned   all_small[LEVEL_COUNT];
        longint unsigned   map_total;
        longint unsigned   layer_total;
        longint unsigned   all_total;
        level_word_t       reports[$];
        int                errors;
        int                samples;
        int                layers;
        int                checked;

        function new();
            level_limit = '{7680, 5120, 2560, 1280, 1024, 768, 512, 256,
                            204, 153, 128, 102, 76, 51, 25, 0};
            foreach (map_small[l]) begin
                map_small[l]   = 0;
                empty_maps[l]  = 0;
                layer_small[l] = 0;
                all_small[l]   = 0;
            end
            map_total   = 0;
            layer_total = 0;
            all_total   = 0;
            errors      = 0;
            samples     = 0;
            layers      = 0;
            checked     = 0;
        endfunction

        function longint unsigned sat_up(longint unsigned v, int bits);
            longint unsigned top;
            top = (bits >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : (64'd1 << bits) - 1;
            return (v >= top) ? top : v + 1;
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] raw, logic map_end, logic layer_end);
            int          value;
            int unsigned mag;
            level_word_t word;
            value = int'($signed(raw));
            mag   = (value < 0) ? -value : value;
            if (mag > 32767)
                mag = 32767;
            samples++;
            map_total   = sat_up(map_total, MAP_COUNT_BITS_DEF);
            layer_total = sat_up(layer_total, LAYER_COUNT_BITS_DEF);
            all_total   = sat_up(all_total, TOTAL_COUNT_BITS_DEF);
            for (int l = 0; l < LEVEL_COUNT; l++) begin
                if (mag <= level_limit[l]) begin
                    map_small[l]   = sat_up(map_small[l], MAP_COUNT_BITS_DEF);
                    layer_small[l] = sat_up(layer_small[l], LAYER_COUNT_BITS_DEF);
                    all_small[l]   = sat_up(all_small[l], TOTAL_COUNT_BITS_DEF);
                end
            end
            if (map_end || layer_end) begin
                for (int l = 0; l < LEVEL_COUNT; l++) begin
                    if (map_small[l] == map_total)
                        empty_maps[l] = sat_up(empty_maps[l], EMPTY_BITS);
                    map_small[l] = 0;
                end
                map_total = 0;
            end
            if (layer_end) begin
                layers++;
                for (int l = 0; l < LEVEL_COUNT; l++) begin
                    word             = '0;
                    word.level       = l[LEVEL_BITS-1:0];
                    word.layer_small = layer_small[l][LAYER_FIELD_W-1:0];
                    word.layer_total = layer_total[LAYER_FIELD_W-1:0];
                    word.all_small   = all_small[l][TOTAL_FIELD_W-1:0];
                    word.all_total   = all_total[TOTAL_FIELD_W-1:0];
                    word.empty_maps  = empty_maps[l][EMPTY_FIELD_W-1:0];
                    reports.push_back(word);
                    layer_small[l] = 0;
                    empty_maps[l]  = 0;
                end
                layer_total = 0;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_level(logic [OUT_DATA_W-1:0] data, logic last);
            level_word_t want;
            level_word_t got;
            got = data;
            if (reports.size() == 0) begin
                $error("level report %0d arrived with none pending", got.level);
                errors++;
                return;
            end
            want = reports.pop_front();
            checked++;
            compare_field("level", 32'(want.level), 32'(got.level));
            compare_field("layer_small_count", 32'(want.layer_small), 32'(got.layer_small));
            compare_field("layer_sample_count", 32'(want.layer_total), 32'(got.layer_total));
            compare_field("total_small_count", want.all_small, got.all_small);
            compare_field("total_sample_count", want.all_total, got.all_total);
            compare_field("empty_map_count", 32'(want.empty_maps), 32'(got.empty_maps));
            compare_field("last_level", 32'(want.level == LEVEL_COUNT - 1), 32'(last));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;

    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    longint        cycles         = 0;
    sparsity_tally tally          = new();

    multi_threshold_sparsity_counter_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready)
            tally.check_level(m_tdata, m_tlast);
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_multi_threshold_sparsity_counter_core: errors");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic map_end,
                               input logic layer_end);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= map_end;
        s_tlast  <= layer_end;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tally.note_sample(value, map_end, layer_end);
        @(negedge aclk);
    endtask

    task automatic send_boundaries();
        int unsigned t;
        send_sample(16'h0000, 1'b1, 1'b0);
        send_sample(16'h7FFF, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h8001, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        for (int l = 0; l < LEVEL_COUNT; l++) begin
            t = tally.level_limit[l];
            send_sample((l % 2 == 0) ? 16'(t) : 16'(-(int'(t) + 1)),
                        (l == 11 || l == 15), (l == 7 || l == 15));
        end
    endtask

    task automatic send_layer();
        int               maps;
        int               len;
        int unsigned      cap;
        int unsigned      mag;
        int unsigned      pick;
        logic [SAMPLE_BITS-1:0] value;
        logic             last_map;
        logic             last_sample;
        maps = $urandom_range(1, 5);
        for (int m = 0; m < maps; m++) begin
            len      = $urandom_range(1, 10);
            cap      = tally.level_limit[$urandom_range(0, LEVEL_COUNT - 1)];
            last_map = (m == maps - 1);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    mag = $urandom_range(0, cap);
                else
                    mag = cap + $urandom_range(0, 3);
                value = $urandom_range(1) ? 16'(-int'(mag)) : 16'(mag);
                if (pick >= 85)
                    value = 16'($urandom);
                last_sample = (i == len - 1);
                send_sample(value,
                            last_sample && (!last_map || $urandom_range(1) == 1),
                            last_sample && last_map);
            end
        end
    endtask

    initial begin
        int phase_idle[4];
        int phase_stall[4];
        int goal;
        phase_idle  = '{0, 82, 0, 23};
        phase_stall = '{0, 0, 82, 23};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_boundaries();
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            goal = tally.samples + PHASE_SAMPLES;
            while (tally.samples < goal)
                send_layer();
        end
        s_tvalid <= 1'b0;

        while (tally.reports.size() != 0)
            @(posedge aclk);
        repeat (2 * LEVEL_COUNT + 8) @(posedge aclk);

        $display("covered %0d samples over %0d layers, %0d level reports checked",
                 tally.samples, tally.layers, tally.checked);
        $display("including threshold edges, the most negative sample and four idle/stall mixes");
        if (tally.errors == 0) begin
            $display("tb_multi_threshold_sparsity_counter_core: clean");
        end else begin
            $display("tb_multi_threshold_sparsity_counter_core: errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/mtsc_pkg.sv
rtl/core/mtsc_cell.sv
rtl/core/multi_threshold_sparsity_counter_core.sv
rtl/core/mtsc_checker.sv
tb/tb_multi_threshold_sparsity_counter_core.sv
